FILE: sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, register codes and tables for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int COMP_BITS     = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int PROD_BITS     = 2 * COMP_BITS;
   localparam int TERM_BITS     = PROD_BITS + 2;
   localparam int MAG_BITS      = TERM_BITS - 1;
   localparam int SQ_BITS       = 2 * MAG_BITS;
   localparam int ROOT_BITS     = MAG_BITS + 2;
   localparam int SUM_BITS      = 2 * ROOT_BITS;
   localparam int REM_BITS      = ROOT_BITS + 2;
   localparam int LANE_IN_BITS  = ROOT_BITS;
   localparam int ANG_FRAC      = 30;
   localparam int NORM_BITS     = 40;
   localparam int M_BITS        = NORM_BITS + 1;
   localparam int CW            = NORM_BITS + 5;
   localparam int ZB            = 35;
   localparam int RND_SHIFT     = ANG_FRAC - (ANGLE_BITS - 3);
   localparam int RND_BITS      = ZB + 1 - RND_SHIFT;
   localparam int THR_BITS      = 31;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int FRONT_LAT     = 4;
   localparam int LANE_LAT      = CORDIC_STAGES + 4;
   localparam int DEPTH         = FRONT_LAT + ROOT_BITS + 1 + LANE_LAT;

   localparam logic [THR_BITS-1:0]        THR_RESET = THR_BITS'(2048);
   localparam logic signed [ZB-1:0]       PI_Q30    = ZB'(64'sd3373259426);
   localparam logic signed [TERM_BITS-1:0] ONE_Q30  = TERM_BITS'(64'sd1 << (2 * (COMP_BITS - 1)));

   typedef enum logic [0:0] {
      REG_GIMBAL_THRESHOLD = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic signed [TERM_BITS-1:0] c31;
      logic signed [TERM_BITS-1:0] c32;
      logic signed [TERM_BITS-1:0] c33;
      logic signed [TERM_BITS-1:0] rny;
      logic signed [TERM_BITS-1:0] rnx;
      logic signed [TERM_BITS-1:0] rly;
      logic signed [TERM_BITS-1:0] rlx;
   } terms_type;

   // atan(2^-i) in units of 2^-30 rad
   function automatic logic [ZB-1:0] atan_entry(input int i);
      logic [ZB-1:0] t;
      case (i)
         0: t = ZB'(843314857);
         1: t = ZB'(497837829);
         2: t = ZB'(263043837);
         3: t = ZB'(133525159);
         4: t = ZB'(67021688);
         5: t = ZB'(33543516);
         6: t = ZB'(16775851);
         7: t = ZB'(8388437);
         8: t = ZB'(4194283);
         9: t = ZB'(2097149);
         default: t = (i < 31) ? (ZB'(1) << (30 - i)) : '0;
      endcase
      return t;
   endfunction

   // Q.30 to output scale, halves round up
   function automatic logic signed [RND_BITS-1:0] round_q30(input logic signed [ZB-1:0] q);
      logic signed [ZB:0] s;
      s = (ZB+1)'(q) + ((ZB+1)'(1) <<< (RND_SHIFT - 1));
      return RND_BITS'(s >>> RND_SHIFT);
   endfunction

endpackage

FILE: sv/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined CORDIC atan2 lane: quadrant fold, normalization, vectoring
// stages and offset add. Result in Q.30 radians.
// ----------------------------------------------------------------------------
module qte_atan2 (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [qte_pkg::LANE_IN_BITS-1:0] y_in,
   input  logic signed [qte_pkg::LANE_IN_BITS-1:0] x_in,
   output logic signed [qte_pkg::ZB-1:0]       z_out
);
   import qte_pkg::*;

   // fold stage
   logic signed [CW-1:0] px_ff, py_ff, px_in, py_in;
   logic [M_BITS-1:0]    pm_ff, pm_in;
   logic signed [ZB-1:0] off_ff [0:LANE_LAT-2];
   logic                 zero_ff [0:LANE_LAT-2];
   logic signed [ZB-1:0] off_in;
   logic                 zero_in;

   always_comb begin
      logic signed [CW-1:0] xe, ye;
      logic [CW-1:0]        mx, my;
      xe = CW'(x_in);
      ye = CW'(y_in);
      zero_in = (x_in == '0) && (y_in == '0);
      off_in  = '0;
      if (x_in < 0) begin
         off_in = (y_in >= 0) ? PI_Q30 : -PI_Q30;
         xe = -xe;
         ye = -ye;
      end
      px_in = xe;
      py_in = ye;
      mx = xe[CW-1] ? CW'(-xe) : CW'(xe);
      my = ye[CW-1] ? CW'(-ye) : CW'(ye);
      pm_in = M_BITS'(mx | my);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff      <= px_in;
         py_ff      <= py_in;
         pm_ff      <= pm_in;
         off_ff[0]  <= off_in;
         zero_ff[0] <= zero_in;
      end
   end

   // normalize in two stages: coarse shifts then fine shifts
   logic signed [CW-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [M_BITS-1:0]    am_ff, am_in;
   logic signed [CW-1:0] bx_ff, by_ff, bx_in, by_in;

   always_comb begin
      ax_in = px_ff;
      ay_in = py_ff;
      am_in = pm_ff;
      if (am_in[M_BITS-1 -: 32] == '0) begin
         am_in = am_in << 32; ax_in = ax_in <<< 32; ay_in = ay_in <<< 32;
      end
      if (am_in[M_BITS-1 -: 16] == '0) begin
         am_in = am_in << 16; ax_in = ax_in <<< 16; ay_in = ay_in <<< 16;
      end
      if (am_in[M_BITS-1 -: 8] == '0) begin
         am_in = am_in << 8; ax_in = ax_in <<< 8; ay_in = ay_in <<< 8;
      end
   end

   always_comb begin
      logic [M_BITS-1:0] m;
      bx_in = ax_ff;
      by_in = ay_ff;
      m     = am_ff;
      if (m[M_BITS-1 -: 4] == '0) begin
         m = m << 4; bx_in = bx_in <<< 4; by_in = by_in <<< 4;
      end
      if (m[M_BITS-1 -: 2] == '0) begin
         m = m << 2; bx_in = bx_in <<< 2; by_in = by_in <<< 2;
      end
      if (m[M_BITS-1] == 1'b0) begin
         bx_in = bx_in <<< 1; by_in = by_in <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         am_ff <= am_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
   end

   // side data rides alongside the lane
   genvar g;
   generate
      for (g = 1; g < LANE_LAT - 1; g++) begin : g_side
         always_ff @(posedge clock) begin
            if (en) begin
               off_ff[g]  <= off_ff[g-1];
               zero_ff[g] <= zero_ff[g-1];
            end
         end
      end
   endgenerate

   // vectoring stages
   logic signed [CW-1:0] cx_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0] cy_ff [0:CORDIC_STAGES];
   logic signed [ZB-1:0] cz_ff [0:CORDIC_STAGES];

   always_comb begin
      cx_ff[0] = bx_ff;
      cy_ff[0] = by_ff;
      cz_ff[0] = '0;
   end

   generate
      for (g = 0; g < CORDIC_STAGES; g++) begin : g_stage
         logic signed [CW-1:0] x_in, y_in;
         logic signed [ZB-1:0] z_in;
         always_comb begin
            if (cy_ff[g] < 0) begin
               x_in = cx_ff[g] - (cy_ff[g] >>> g);
               y_in = cy_ff[g] + (cx_ff[g] >>> g);
               z_in = cz_ff[g] - $signed(atan_entry(g));
            end else begin
               x_in = cx_ff[g] + (cy_ff[g] >>> g);
               y_in = cy_ff[g] - (cx_ff[g] >>> g);
               z_in = cz_ff[g] + $signed(atan_entry(g));
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               cx_ff[g+1] <= x_in;
               cy_ff[g+1] <= y_in;
               cz_ff[g+1] <= z_in;
            end
         end
      end
   endgenerate

   logic signed [ZB-1:0] z_ff, z_in;

   assign z_in = zero_ff[LANE_LAT-2] ? '0 : cz_ff[CORDIC_STAGES] + off_ff[LANE_LAT-2];

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= z_in;
      end
   end

   assign z_out = z_ff;

endmodule

FILE: sv/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Quaternion (Q1.15) to pitch (Q2.13 rad), yaw and roll (Q3.13 rad) with
// gimbal-lock detection against a programmable threshold.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion per cycle in, one angle set per cycle out
// while rsp is not stalled. The pipeline is mostly the 35-stage bit-per-stage
// square root of the matrix terms followed by three parallel 20-stage CORDIC
// atan2 lanes. A stall on the rsp side freezes the whole pipeline and backs up
// onto req_stall. gimbal_threshold lives at byte address 0 and must only be
// written while the pipeline is empty.
module quaternion_to_euler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [qte_pkg::COMP_BITS-1:0]   req_qx,
   input  logic signed [qte_pkg::COMP_BITS-1:0]   req_qy,
   input  logic signed [qte_pkg::COMP_BITS-1:0]   req_qz,
   input  logic signed [qte_pkg::COMP_BITS-1:0]   req_qw,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [qte_pkg::ANGLE_BITS-2:0]  rsp_pitch,
   output logic signed [qte_pkg::ANGLE_BITS-1:0]  rsp_yaw,
   output logic signed [qte_pkg::ANGLE_BITS-1:0]  rsp_roll,
   output logic                                   rsp_gimbal_lock,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [qte_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [qte_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [qte_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import qte_pkg::*;

   // ---------------- configuration ----------------
   logic [THR_BITS-1:0] thr_ff;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_BITS-1] == REG_GIMBAL_THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         thr_ff <= csr_pwdata[THR_BITS-1:0];
      end
   end

   assign csr_prdata = reg_sel ? CSR_DATA_BITS'(thr_ff) : '0;

   // ---------------- flow control ----------------
   logic             adv;
   logic [DEPTH-1:0] v_ff;
   logic             rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[DEPTH-2:0], req_valid};
         rsp_valid_ff <= v_ff[DEPTH-1];
      end
   end

   // ---------------- products ----------------
   logic signed [PROD_BITS-1:0] p_aa_ff, p_bb_ff, p_cc_ff, p_ab_ff, p_cd_ff;
   logic signed [PROD_BITS-1:0] p_ac_ff, p_bd_ff, p_bc_ff, p_ad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_aa_ff <= req_qx * req_qx;
         p_bb_ff <= req_qy * req_qy;
         p_cc_ff <= req_qz * req_qz;
         p_ab_ff <= req_qx * req_qy;
         p_cd_ff <= req_qz * req_qw;
         p_ac_ff <= req_qx * req_qz;
         p_bd_ff <= req_qy * req_qw;
         p_bc_ff <= req_qy * req_qz;
         p_ad_ff <= req_qx * req_qw;
      end
   end

   // ---------------- matrix terms ----------------
   terms_type t_ff, t_in;

   always_comb begin
      logic signed [TERM_BITS-1:0] aa2, bb2, cc2, ab2, cd2, ac2, bd2, bc2, ad2;
      aa2 = TERM_BITS'(p_aa_ff) <<< 1;
      bb2 = TERM_BITS'(p_bb_ff) <<< 1;
      cc2 = TERM_BITS'(p_cc_ff) <<< 1;
      ab2 = TERM_BITS'(p_ab_ff) <<< 1;
      cd2 = TERM_BITS'(p_cd_ff) <<< 1;
      ac2 = TERM_BITS'(p_ac_ff) <<< 1;
      bd2 = TERM_BITS'(p_bd_ff) <<< 1;
      bc2 = TERM_BITS'(p_bc_ff) <<< 1;
      ad2 = TERM_BITS'(p_ad_ff) <<< 1;
      t_in.c31 = ac2 + bd2;
      t_in.c32 = bc2 - ad2;
      t_in.c33 = ONE_Q30 - aa2 - bb2;
      t_in.rny = ab2 + cd2;
      t_in.rnx = ONE_Q30 - aa2 - cc2;
      t_in.rly = cd2 - ab2;
      t_in.rlx = ONE_Q30 - bb2 - cc2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff <= t_in;
      end
   end

   // ---------------- squares and sum ----------------
   terms_type          ts_ff;
   logic [SQ_BITS-1:0] sq33_ff, sq31_ff;
   logic [MAG_BITS-1:0] m33, m31;

   assign m33 = t_ff.c33[TERM_BITS-1] ? MAG_BITS'(-t_ff.c33) : MAG_BITS'(t_ff.c33);
   assign m31 = t_ff.c31[TERM_BITS-1] ? MAG_BITS'(-t_ff.c31) : MAG_BITS'(t_ff.c31);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq33_ff <= m33 * m33;
         sq31_ff <= m31 * m31;
         ts_ff   <= t_ff;
      end
   end

   // ---------------- square root, one result bit per stage ----------------
   logic [SUM_BITS-1:0]  rs_ff   [0:ROOT_BITS];
   logic [REM_BITS-1:0]  rr_ff   [0:ROOT_BITS];
   logic [ROOT_BITS-1:0] rq_ff   [0:ROOT_BITS];
   terms_type            rt_ff   [0:ROOT_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         rs_ff[0] <= SUM_BITS'(sq33_ff) + SUM_BITS'(sq31_ff);
         rr_ff[0] <= '0;
         rq_ff[0] <= '0;
         rt_ff[0] <= ts_ff;
      end
   end

   genvar g;
   generate
      for (g = 0; g < ROOT_BITS; g++) begin : g_sqrt
         logic [REM_BITS+1:0] cur, trial;
         logic [REM_BITS-1:0] rem_in;
         logic [ROOT_BITS-1:0] root_in;
         always_comb begin
            cur   = {rr_ff[g], rs_ff[g][SUM_BITS-1 -: 2]};
            trial = (REM_BITS+2)'({rq_ff[g], 2'b01});
            if (cur >= trial) begin
               rem_in  = REM_BITS'(cur - trial);
               root_in = {rq_ff[g][ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = REM_BITS'(cur);
               root_in = {rq_ff[g][ROOT_BITS-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               rs_ff[g+1] <= rs_ff[g] << 2;
               rr_ff[g+1] <= rem_in;
               rq_ff[g+1] <= root_in;
               rt_ff[g+1] <= rt_ff[g];
            end
         end
      end
   endgenerate

   // ---------------- round root, pick path, load lanes ----------------
   logic [ROOT_BITS-1:0] horiz;
   logic                 lock_in;
   terms_type            tf;
   logic signed [LANE_IN_BITS-1:0] py_ff, px_ff, yy_ff, yx_ff, ry_ff, rx_ff;
   logic                 lock_ff [0:LANE_LAT];

   assign tf      = rt_ff[ROOT_BITS];
   assign horiz   = (rr_ff[ROOT_BITS] > REM_BITS'(rq_ff[ROOT_BITS]))
                    ? rq_ff[ROOT_BITS] + ROOT_BITS'(1) : rq_ff[ROOT_BITS];
   assign lock_in = !(horiz > ROOT_BITS'(thr_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         py_ff      <= -LANE_IN_BITS'(tf.c32);
         px_ff      <= $signed(horiz);
         yy_ff      <= LANE_IN_BITS'(tf.c31);
         yx_ff      <= LANE_IN_BITS'(tf.c33);
         ry_ff      <= lock_in ? LANE_IN_BITS'(tf.rly) : LANE_IN_BITS'(tf.rny);
         rx_ff      <= lock_in ? LANE_IN_BITS'(tf.rlx) : LANE_IN_BITS'(tf.rnx);
         lock_ff[0] <= lock_in;
      end
   end

   generate
      for (g = 0; g < LANE_LAT; g++) begin : g_lock
         always_ff @(posedge clock) begin
            if (adv) begin
               lock_ff[g+1] <= lock_ff[g];
            end
         end
      end
   endgenerate

   logic signed [ZB-1:0] pz, yz, rz;

   qte_atan2 u_pitch (.clock(clock), .en(adv), .y_in(py_ff), .x_in(px_ff), .z_out(pz));
   qte_atan2 u_yaw   (.clock(clock), .en(adv), .y_in(yy_ff), .x_in(yx_ff), .z_out(yz));
   qte_atan2 u_roll  (.clock(clock), .en(adv), .y_in(ry_ff), .x_in(rx_ff), .z_out(rz));

   // ---------------- round, saturate, output register ----------------
   localparam logic signed [RND_BITS-1:0] P_MAX = RND_BITS'((64'sd1 <<< (ANGLE_BITS - 2)) - 1);
   localparam logic signed [RND_BITS-1:0] A_MAX = RND_BITS'((64'sd1 <<< (ANGLE_BITS - 1)) - 1);

   logic signed [RND_BITS-1:0] pr, yr, rr;
   logic signed [ANGLE_BITS-2:0] pitch_in;
   logic signed [ANGLE_BITS-1:0] yaw_in, roll_in;
   logic signed [ANGLE_BITS-2:0] pitch_ff;
   logic signed [ANGLE_BITS-1:0] yaw_ff, roll_ff;
   logic                         glock_ff;

   assign pr = round_q30(pz);
   assign yr = round_q30(yz);
   assign rr = round_q30(rz);

   always_comb begin
      if (pr > P_MAX)            pitch_in = (ANGLE_BITS-1)'(P_MAX);
      else if (pr < -P_MAX - 1)  pitch_in = (ANGLE_BITS-1)'(-P_MAX - 1);
      else                       pitch_in = (ANGLE_BITS-1)'(pr);
      if (yr > A_MAX)            yaw_in = ANGLE_BITS'(A_MAX);
      else if (yr < -A_MAX - 1)  yaw_in = ANGLE_BITS'(-A_MAX - 1);
      else                       yaw_in = ANGLE_BITS'(yr);
      if (rr > A_MAX)            roll_in = ANGLE_BITS'(A_MAX);
      else if (rr < -A_MAX - 1)  roll_in = ANGLE_BITS'(-A_MAX - 1);
      else                       roll_in = ANGLE_BITS'(rr);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pitch_ff <= pitch_in;
         yaw_ff   <= lock_ff[LANE_LAT] ? '0 : yaw_in;
         roll_ff  <= roll_in;
         glock_ff <= lock_ff[LANE_LAT];
      end
   end

   assign rsp_pitch       = pitch_ff;
   assign rsp_yaw         = yaw_ff;
   assign rsp_roll        = roll_ff;
   assign rsp_gimbal_lock = glock_ff;

endmodule
